[sv/b64d_pkg.sv]
// Shared types and constants for the lenient base64 decoder.
// No dependencies; imported by the front, queue, back and top modules.
package b64d_pkg;

   localparam int BURST_MAX   = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_PAD     = 8'h3D;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_PLUS       = 6'd62;
   localparam logic [5:0] SEXTET_SLASH      = 6'd63;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   // Up to three result bytes produced by one request, oldest in slot 0.
   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [1:0]                last_idx;
      logic                      byte_valid;
      logic                      done;
   } burst_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   function automatic sextet_type sextet_decode(input logic [7:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = '0;
      case (c) inside
         [CHAR_UPPER_A:CHAR_UPPER_Z]: s.value = 6'(c - CHAR_UPPER_A);
         [CHAR_LOWER_A:CHAR_LOWER_Z]: s.value = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
         [CHAR_DIGIT_0:CHAR_DIGIT_9]: s.value = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
         CHAR_PLUS:                   s.value = SEXTET_PLUS;
         CHAR_SLASH:                  s.value = SEXTET_SLASH;
         default:                     s.valid = 1'b0;
      endcase
      return s;
   endfunction

endpackage

[sv/b64d_front.sv]
// Front end: accepts characters, decodes sextets, gathers groups and
// pushes byte bursts into the queue. Depends on b64d_pkg.
module b64d_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,
   input  logic                         req_tlast,
   input  b64d_pkg::queue_status_type   queue_status,
   output logic                         push,
   output b64d_pkg::burst_type          push_data
);
   import b64d_pkg::*;

   logic [17:0] store_ff, store_in;
   logic [1:0]  count_ff, count_in;
   logic        pad_ff, pad_in;
   logic        emit;
   logic        accept;
   sextet_type  sx;
   logic [23:0] full;
   burst_type   burst;

   assign req_tready = !queue_status.full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && emit;
   assign push_data  = burst;

   always_comb begin
      store_in = store_ff;
      count_in = count_ff;
      pad_in   = pad_ff;
      emit     = 1'b0;
      burst    = '0;
      sx       = sextet_decode(req_tdata);
      full     = {store_ff, sx.value};
      if (!pad_ff) begin
         if (req_tdata == CHAR_PAD) begin
            pad_in = 1'b1;
         end else if (sx.valid) begin
            if (count_ff == 2'd3) begin
               emit             = 1'b1;
               burst.bytes[0]   = full[23:16];
               burst.bytes[1]   = full[15:8];
               burst.bytes[2]   = full[7:0];
               burst.last_idx   = 2'd2;
               burst.byte_valid = 1'b1;
               store_in         = '0;
               count_in         = '0;
            end else begin
               store_in = {store_ff[11:0], sx.value};
               count_in = count_ff + 2'd1;
            end
         end
      end
      if (req_tlast) begin
         burst.done = 1'b1;
         if (!emit) begin
            case (count_in)
               2'd2: begin
                  burst.bytes[0]   = store_in[11:4];
                  burst.byte_valid = 1'b1;
               end
               2'd3: begin
                  burst.bytes[0]   = store_in[17:10];
                  burst.bytes[1]   = store_in[9:2];
                  burst.last_idx   = 2'd1;
                  burst.byte_valid = 1'b1;
               end
               default: begin
                  burst.byte_valid = 1'b0;
               end
            endcase
         end
         emit     = 1'b1;
         store_in = '0;
         count_in = '0;
         pad_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         count_ff <= '0;
         pad_ff   <= 1'b0;
      end else if (accept) begin
         store_ff <= store_in;
         count_ff <= count_in;
         pad_ff   <= pad_in;
      end
   end

   a_eom_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> count_ff == 2'd0 && !pad_ff && store_ff == '0)
      else $error("state not cleared after end of message");
   a_store_width: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd1 |-> store_ff[17:6] == '0)
      else $error("stale sextets above the pending group");
   a_pad_freezes: assert property (@(posedge clock) disable iff (reset)
      pad_ff && accept && !req_tlast |=> $stable(count_ff) && $stable(store_ff))
      else $error("decoding advanced after pad");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      queue_status.full |-> !push)
      else $error("push into full queue");

endmodule

[sv/b64d_queue.sv]
// Burst queue between front and back ends, a small register FIFO.
// Depends on b64d_pkg.
module b64d_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  b64d_pkg::burst_type          push_data,
   input  logic                         pop,
   output b64d_pkg::burst_type          head,
   output b64d_pkg::queue_status_type   status
);
   import b64d_pkg::*;

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   burst_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [LEVEL_W-1:0] level_ff, level_in;

   assign head             = mem_ff[rd_ptr_ff];
   assign status.not_empty = level_ff != '0;
   assign status.full      = level_ff == LEVEL_W'(QUEUE_DEPTH);

   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + LEVEL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         level_ff <= level_in;
      end
   end

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(QUEUE_DEPTH))
      else $error("queue level out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !status.not_empty |-> !pop)
      else $error("pop from empty queue");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      level_ff != LEVEL_W'(QUEUE_DEPTH) |-> PTR_W'(wr_ptr_ff - rd_ptr_ff) == PTR_W'(level_ff))
      else $error("queue pointers disagree with level");

endmodule

[sv/b64d_back.sv]
// Back end: unpacks queued bursts into single bytes behind an output register.
// Depends on b64d_pkg.
module b64d_back (
   input  logic                         clock,
   input  logic                         reset,
   input  b64d_pkg::burst_type          head,
   input  b64d_pkg::queue_status_type   queue_status,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,
   output logic                         rsp_tuser,
   output logic                         rsp_tlast
);
   import b64d_pkg::*;

   logic       valid_ff;
   logic [7:0] data_ff, data_in;
   logic       user_ff, user_in;
   logic       last_ff, last_in;
   logic [1:0] index_ff, index_in;
   logic       load;
   logic       at_end;

   assign load       = !valid_ff || rsp_tready;
   assign at_end     = index_ff == head.last_idx;
   assign pop        = load && queue_status.not_empty && at_end;
   assign data_in    = head.bytes[index_ff];
   assign user_in    = head.byte_valid;
   assign last_in    = head.done && at_end;
   assign index_in   = at_end ? 2'd0 : index_ff + 2'd1;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= '0;
      end else if (load) begin
         valid_ff <= queue_status.not_empty;
         if (queue_status.not_empty) begin
            index_ff <= index_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && queue_status.not_empty) begin
         data_ff <= data_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
   end

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      queue_status.not_empty |-> index_ff <= head.last_idx)
      else $error("byte index past end of burst");
   a_index_idle: assert property (@(posedge clock) disable iff (reset)
      !queue_status.not_empty |-> index_ff == 2'd0)
      else $error("byte index left mid-burst with empty queue");
   a_empty_marks_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata == 8'd0)
      else $error("empty result not marked as message end");

endmodule

[sv/base64_lenient_decoder_core.sv]
// Lenient base64 decoder: accepts at most one character per cycle, none while
// the burst queue is full, and returns bytes. Each fourth symbol yields three
// result bytes, which the back end returns one per cycle while the receiver
// is ready; sustained throughput is one byte per cycle, set by the output
// register, with a four-entry burst queue absorbing the 3-byte groups. Bytes
// pass through the burst queue, then the output register. Symbols outside the
// alphabet are skipped, the first pad stops decoding, and each end-of-message
// request yields a result with tlast set (tuser clear if no byte was due).
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
module base64_lenient_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic       rsp_tuser,   // byte_valid
   output logic       rsp_tlast    // message_done
);
   import b64d_pkg::*;

   logic             push;
   logic             pop;
   burst_type        push_data;
   burst_type        head;
   queue_status_type queue_status;

   b64d_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (queue_status)
   );

   b64d_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

[bench/tb_base64_lenient_decoder_core.sv]
// Self-checking bench for base64_lenient_decoder_core: directed and random character
// streams on the request side, every returned byte checked against an in-bench decoder.
// Depends on b64d_pkg and the decoder RTL.
module tb_base64_lenient_decoder_core;
   timeunit 1ns;
   timeprecision 1ps;

   import b64d_pkg::*;

   typedef struct packed {
      logic [7:0] code;
      logic       eom;
      logic       hold;
   } char_req_type;

   typedef struct packed {
      logic [7:0] data;
      logic       byte_valid;
      logic       done;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;

   char_req_type char_feed[$];
   decoded_type  pending_bytes[$];

   logic [17:0] dec_store = '0;
   logic [1:0]  dec_count = '0;
   logic        dec_pad = 1'b0;

   int errors = 0;
   int chars_sent = 0;
   int messages_sent = 0;
   int results_seen = 0;
   int bytes_seen = 0;
   int burst_left = 0;
   int gap_left = 0;
   int long_hold_left = 0;
   bit long_hold_done = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   int pattern_age = 0;
   decoded_type got;

   base64_lenient_decoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // {is_symbol, value}
   function automatic logic [6:0] symbol_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = c - CHAR_UPPER_A;
         return {1'b1, d[5:0]};
      end
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = c - CHAR_LOWER_A + 8'd26;
         return {1'b1, d[5:0]};
      end
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d = c - CHAR_DIGIT_0 + 8'd52;
         return {1'b1, d[5:0]};
      end
      if (c == CHAR_PLUS) return {1'b1, 6'd62};
      if (c == CHAR_SLASH) return {1'b1, 6'd63};
      return 7'd0;
   endfunction

   function automatic logic [7:0] char_of_symbol(input int idx);
      if (idx < 26) return CHAR_UPPER_A + 8'(idx);
      if (idx < 52) return CHAR_LOWER_A + 8'(idx - 26);
      if (idx < 62) return CHAR_DIGIT_0 + 8'(idx - 52);
      if (idx == 62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (symbol_of(c) != 7'd0 || c == CHAR_PAD) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic decode_char(input logic [7:0] code, input logic eom);
      decoded_type outs[3];
      int          n;
      logic [6:0]  sym;
      logic [23:0] word;
      n = 0;
      sym = symbol_of(code);
      if (!dec_pad) begin
         if (code == CHAR_PAD) begin
            dec_pad = 1'b1;
         end else if (sym[6]) begin
            if (dec_count == 2'd3) begin
               word = {dec_store, sym[5:0]};
               outs[0] = {word[23:16], 1'b1, 1'b0};
               outs[1] = {word[15:8], 1'b1, 1'b0};
               outs[2] = {word[7:0], 1'b1, 1'b0};
               n = 3;
               dec_store = '0;
               dec_count = '0;
            end else begin
               dec_store = {dec_store[11:0], sym[5:0]};
               dec_count = dec_count + 2'd1;
            end
         end
      end
      if (eom) begin
         if (n > 0) begin
            outs[n-1].done = 1'b1;
         end else if (dec_count == 2'd2) begin
            outs[0] = {dec_store[11:4], 1'b1, 1'b1};
            n = 1;
         end else if (dec_count == 2'd3) begin
            outs[0] = {dec_store[17:10], 1'b1, 1'b0};
            outs[1] = {dec_store[9:2], 1'b1, 1'b1};
            n = 2;
         end else begin
            outs[0] = {8'h00, 1'b0, 1'b1};
            n = 1;
         end
         dec_store = '0;
         dec_count = '0;
         dec_pad = 1'b0;
      end
      for (int i = 0; i < n; i++) pending_bytes.push_back(outs[i]);
   endtask

   task automatic add_char(input logic [7:0] code, input logic eom, input logic hold);
      char_feed.push_back({code, eom, hold});
   endtask

   task automatic add_text(input string s, input logic eom_at_end, input logic hold);
      for (int i = 0; i < s.len(); i++)
         add_char(s[i], eom_at_end && (i == s.len() - 1), hold && (i == 0));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_char(req_tdata, req_tlast);
            void'(char_feed.pop_front());
            chars_sent++;
            if (req_tlast) messages_sent++;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         if (req_tvalid && !req_tready) begin
            // hold the offered request
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (char_feed.size() == 0 ||
                      (char_feed[0].hold && pending_bytes.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= char_feed[0].code;
            req_tlast  <= char_feed[0].eom;
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_bytes.size() == 0) begin
               $error("unexpected result: data_byte %02h byte_valid %0b message_done %0b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               errors++;
            end else begin
               got = pending_bytes.pop_front();
               results_seen++;
               if (rsp_tuser) bytes_seen++;
               if (rsp_tdata !== got.data) begin
                  $error("data_byte mismatch: expected %02h, got %02h", got.data, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser !== got.byte_valid) begin
                  $error("byte_valid mismatch: expected %0b, got %0b",
                         got.byte_valid, rsp_tuser);
                  errors++;
               end
               if (rsp_tlast !== got.done) begin
                  $error("message_done mismatch: expected %0b, got %0b", got.done, rsp_tlast);
                  errors++;
               end
            end
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && results_seen >= 30) begin
            long_hold_done = 1;
            long_hold_left = 199;
            rsp_tready <= 1'b0;
         end else begin
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            rsp_tready <= stall_pattern[0];
            pattern_age++;
            if (pattern_age == 48) begin
               pattern_age = 0;
               case ($urandom_range(0, 3))
                  0: stall_pattern = 16'hFFFF;
                  1: stall_pattern = 16'($urandom);
                  2: stall_pattern = 16'($urandom) | 16'($urandom);
                  default: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
               endcase
            end
         end
      end
   end

   initial begin
      logic [7:0] msg_codes[$];
      int rand_items;
      int kind;
      int nsym;
      bit first_msg;
      rand_items = 0;
      first_msg = 1;

      add_text("TWFu", 1, 0);
      add_char(8'h00, 0, 1);
      add_text("////", 0, 0);
      add_char(8'hFF, 1, 0);
      add_text("+9z=Q=", 1, 0);
      add_text("aZ", 1, 0);
      add_text("A", 1, 0);
      add_char(8'h80, 1, 0);
      add_text("=", 1, 0);
      add_text("AA09", 1, 0);

      while (rand_items < 145) begin
         msg_codes.delete();
         kind = $urandom_range(0, 9);
         nsym = $urandom_range(0, 13);
         if (kind <= 6) begin
            for (int i = 0; i < nsym; i++) begin
               if (kind >= 5 && $urandom_range(0, 3) == 0) msg_codes.push_back(noise_char());
               msg_codes.push_back(char_of_symbol($urandom_range(0, 63)));
            end
            if (nsym % 4 == 2 && $urandom_range(0, 1) == 1) begin
               msg_codes.push_back(CHAR_PAD);
               msg_codes.push_back(CHAR_PAD);
            end else if (nsym % 4 == 3 && $urandom_range(0, 1) == 1) begin
               msg_codes.push_back(CHAR_PAD);
            end
         end else begin
            for (int i = 0; i < nsym; i++) begin
               case ($urandom_range(0, 3))
                  0: msg_codes.push_back(8'($urandom_range(0, 255)));
                  1: msg_codes.push_back(CHAR_PAD);
                  default: msg_codes.push_back(char_of_symbol($urandom_range(0, 63)));
               endcase
            end
         end
         if (msg_codes.size() == 0) msg_codes.push_back(8'($urandom_range(0, 255)));
         for (int i = 0; i < msg_codes.size(); i++)
            add_char(msg_codes[i], i == msg_codes.size() - 1, first_msg && i == 0);
         rand_items += msg_codes.size();
         first_msg = 0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (char_feed.size() != 0 || req_tvalid) @(posedge clock);
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         $error("%0d results never arrived", pending_bytes.size());
         errors++;
      end
      $display("sent %0d characters in %0d messages; checked %0d results, %0d data bytes",
               chars_sent, messages_sent, results_seen, bytes_seen);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #500000;
      $display("simulation failed");
      $finish;
   end

endmodule

[filelist.f]
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_lenient_decoder_core.sv
bench/tb_base64_lenient_decoder_core.sv
